[src/i2ctds_pkg.sv]
// ----------------------------------------------------------------------------
// i2ctds_pkg
// Shared types and constants for the I2C timing divider search block.
// ----------------------------------------------------------------------------
`default_nettype none

package i2ctds_pkg;

    // Width of the shared divider operands
    localparam int DIV_W = 30;

    // Input clock after reset, in hertz
    localparam logic [DIV_W-1:0] CLOCK_RESET_HZ = 30'd66666666;

    // Fixed cycle overhead taken off the raw clock ratio
    localparam int FIXED_OVERHEAD = 8;

    // Quotient span: period = quotient - 2 must stay in 2..511
    localparam int PERIOD_OFFSET = 2;
    localparam int QUOT_MIN      = 4;
    localparam int QUOT_SPAN     = 514;

    // Reciprocal of 257 scaled by 2^24, exact for (base/2) below 2^24:
    // base/514 = ((base >> 1) * QUOT_SPAN_RECIP) >> 24
    localparam logic [15:0] QUOT_SPAN_RECIP = 16'd65281;

    // Packed result width before byte padding
    localparam int RES_W = 113;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_RATE,
        ST_DIV_BASE,
        ST_DIV_PERIOD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

[src/i2ctds_div.sv]
// ----------------------------------------------------------------------------
// i2ctds_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module i2ctds_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire i2ctds_pkg::div_req_t            req,
    output i2ctds_pkg::div_stat_t                stat,
    output logic [i2ctds_pkg::DIV_W-1:0]         quotient
);
    import i2ctds_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             done_reg, done_next;
    logic [DIV_W-1:0] acc_reg,  acc_next;
    logic [DIV_W-1:0] rem_reg,  rem_next;
    logic [DIV_W-1:0] dsr_reg,  dsr_next;

    logic [DIV_W:0]   rem_shift;
    logic [DIV_W:0]   rem_diff;
    logic             fits;

    // Trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        rem_shift = {rem_reg, acc_reg[DIV_W-1]};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        fits      = rem_shift >= {1'b0, dsr_reg};
    end

    // Load on start, else advance one bit while busy
    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            cnt_next = CNT_W'(DIV_W);
            acc_next = req.dividend;
            rem_next = '0;
            dsr_next = req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
            acc_next  = {acc_reg[DIV_W-2:0], fits};
            rem_next  = fits ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Operand and partial result
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = acc_reg;

endmodule

`default_nettype wire

[src/i2c_timing_divider_search_top.sv]
// ----------------------------------------------------------------------------
// i2c_timing_divider_search_top
// Works out the I2C clock divider and fast-mode timing words for a bus rate.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                      Beat contents
//  s_*       in         s_tvalid s_tready s_tdata    bus_rate_hz, filter_cycles
//  m_*       out        m_tvalid m_tready m_tdata    ok, divider, period, words
//  cfg_*     in         cfg_we cfg_wdata             input_clock_hz
//
//  One beat in gives one beat out: two passes of the shared 30-bit radix-2
//  divider (clock/rate, base/(divider+1)), a state that picks the divider as
//  base/514 by reciprocal multiply and a state that loads the result. The next
//  beat is taken once the block is back in idle. A zero rate skips both passes;
//  a negative base or a base past the divider range skips the second. s_tready
//  is high only while idle; the result waits in an output register, and
//  back-pressure on a full register holds the block until it can load the
//  result. Reset sets the clock to 66666666 Hz.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_timing_divider_search_top #(
    parameter int DIVIDER_LIMIT = 256
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [22:0] bus_rate_hz, [25:23] filter_cycles
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [119:0]      m_tdata,   // [0] ok, [8:1] clock_divider,
                                         // [17:9] period_cycles,
                                         // [49:18] timing_word_one,
                                         // [81:50] timing_word_two,
                                         // [105:82] timing_word_three,
                                         // [112:106] data_hold_word
    input  wire logic         cfg_we,
    input  wire logic [29:0]  cfg_wdata
);
    import i2ctds_pkg::*;

    state_t           state_reg, state_next;
    logic [DIV_W-1:0] clk_hz_reg, clk_hz_next;
    logic             out_valid_reg, out_valid_next;
    logic [RES_W-1:0] out_data_reg, out_data_next;
    logic [2:0]       filt_reg, filt_next;
    logic [DIV_W-1:0] base_reg, base_next;
    logic [7:0]       dsel_reg, dsel_next;
    logic [8:0]       period_reg, period_next;
    logic             fail_reg, fail_next;

    div_req_t         div_req;
    div_stat_t        div_stat;
    logic [DIV_W-1:0] div_quot;

    logic [22:0]      in_rate;
    logic [2:0]       in_filt;
    logic             in_beat;
    logic             rate_zero;
    logic [DIV_W-1:0] overhead;
    logic             base_short;
    logic [DIV_W-1:0] base_calc;
    logic             base_over;
    logic [31:0]      recip_prod;
    logic [7:0]       dsel_pick;
    logic             quot_short;
    logic             out_free;
    logic [7:0]       half_p;
    logic [6:0]       quarter_p;
    logic [RES_W-1:0] packed_res;

    i2ctds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // Decode the input beat and the checks between divider passes
    always_comb
    begin
        in_rate    = s_tdata[22:0];
        in_filt    = s_tdata[25:23];
        in_beat    = s_tvalid && s_tready;
        rate_zero  = (in_rate == '0);
        overhead   = DIV_W'(FIXED_OVERHEAD) + DIV_W'({filt_reg, 1'b0});
        base_short = div_quot < overhead;
        base_calc  = div_quot - overhead;
        base_over  = base_reg >= DIV_W'(DIVIDER_LIMIT * QUOT_SPAN);
        // First fitting divider is base/514; base is below 131584 when used
        recip_prod = 32'(base_reg[17:1]) * 32'(QUOT_SPAN_RECIP);
        dsel_pick  = recip_prod[31:24];
        quot_short = div_quot < DIV_W'(QUOT_MIN);
        out_free   = !out_valid_reg || m_tready;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                    state_next = rate_zero ? ST_FINISH : ST_DIV_RATE;
            end
            ST_DIV_RATE:
            begin
                if (div_stat.done)
                    state_next = base_short ? ST_FINISH : ST_DIV_BASE;
            end
            ST_DIV_BASE:
            begin
                state_next = base_over ? ST_FINISH : ST_DIV_PERIOD;
            end
            ST_DIV_PERIOD:
            begin
                if (div_stat.done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Pack the timing words from the chosen divider and period
    always_comb
    begin
        half_p     = period_reg[8:1];
        quarter_p  = period_reg[8:2];
        packed_res = {quarter_p,
                      dsel_reg, 7'b0, period_reg,
                      1'b0, quarter_p, 8'b0, half_p, half_p,
                      half_p, half_p, half_p, 8'b0,
                      period_reg,
                      dsel_reg,
                      1'b1};
    end

    // Divider requests, datapath updates and result register
    always_comb
    begin
        s_tready       = (state_reg == ST_IDLE);
        div_req        = '0;
        clk_hz_next    = cfg_we ? cfg_wdata : clk_hz_reg;
        filt_next      = filt_reg;
        base_next      = base_reg;
        dsel_next      = dsel_reg;
        period_next    = period_reg;
        fail_next      = fail_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    filt_next        = in_filt;
                    fail_next        = rate_zero;
                    div_req.start    = !rate_zero;
                    div_req.dividend = clk_hz_reg;
                    div_req.divisor  = DIV_W'(in_rate);
                end
            end
            ST_DIV_RATE:
            begin
                if (div_stat.done)
                begin
                    base_next = base_calc;
                    fail_next = base_short;
                end
            end
            ST_DIV_BASE:
            begin
                dsel_next        = dsel_pick;
                fail_next        = base_over;
                div_req.start    = !base_over;
                div_req.dividend = base_reg;
                div_req.divisor  = DIV_W'(dsel_pick) + DIV_W'(1);
            end
            ST_DIV_PERIOD:
            begin
                if (div_stat.done)
                begin
                    period_next = 9'(div_quot - DIV_W'(PERIOD_OFFSET));
                    fail_next   = quot_short;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = fail_reg ? '0 : packed_res;
                end
            end
            default:
            begin
                fail_next = 1'b1;
            end
        endcase
    end

    // Control state and the clock register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clk_hz_reg    <= CLOCK_RESET_HZ;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clk_hz_reg    <= clk_hz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        filt_reg     <= filt_next;
        base_reg     <= base_next;
        dsel_reg     <= dsel_next;
        period_reg   <= period_next;
        fail_reg     <= fail_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_data_reg};

    // A found period lies in 2..511
    a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[17:9] >= 9'd2)
        else $error("period out of range on a good result");

    // A failed search clears every field
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[112:1] == '0)
        else $error("failed result carries non-zero fields");

    // The divider runs only during a divide pass
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_DIV_RATE || state_reg == ST_DIV_BASE ||
                           state_reg == ST_DIV_PERIOD))
        else $error("divider busy outside a divide pass");

    // A non-zero rate starts the first divide pass at once
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata[22:0] != '0 |=> div_stat.busy)
        else $error("divider not started after an input beat");

endmodule

`default_nettype wire

[sim/i2ctds_checker.sv]
// ----------------------------------------------------------------------------
// i2ctds_checker
// Predicts and checks the timing words of the I2C divider search block.
// ----------------------------------------------------------------------------
// Watches the configuration port and both stream channels. Keeps its own copy
// of the input clock setting. Works out the expected result for every beat
// accepted on the slave side. Compares every result beat, field by field, with
// the oldest expectation. Hands the failure count and the number of results
// still outstanding to the testbench top.
// ----------------------------------------------------------------------------

module i2ctds_checker #(
    parameter int DIVIDER_LIMIT = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [31:0]  s_tdata,   // [22:0] bus_rate_hz, [25:23] filter_cycles
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [119:0] m_tdata,   // [0] ok, [8:1] clock_divider,
                                    // [17:9] period_cycles,
                                    // [49:18] timing_word_one,
                                    // [81:50] timing_word_two,
                                    // [105:82] timing_word_three,
                                    // [112:106] data_hold_word
    input  logic         cfg_we,
    input  logic [29:0]  cfg_wdata,
    output int           fail_count,
    output int           pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import i2ctds_pkg::*;

    // Legal span of the SCL period in divided clocks
    localparam longint PERIOD_LOW  = 2;
    localparam longint PERIOD_HIGH = 512;

    typedef struct packed {
        logic        ok;
        logic [7:0]  divider;
        logic [8:0]  period;
        logic [31:0] word_one;
        logic [31:0] word_two;
        logic [23:0] word_three;
        logic [6:0]  data_hold;
    } timing_words_t;

    logic [29:0]   clock_hz;
    timing_words_t timing_q[$];
    int            beats_in;
    int            beats_out;

    assign pending = beats_in - beats_out;

    // Search the dividers in order and pack the timing words of the first fit
    function automatic timing_words_t search_timing(
        input logic [29:0] clk_hz,
        input logic [22:0] rate,
        input logic [2:0]  filt
    );
        timing_words_t res;
        longint        ratio;
        longint        base;
        longint        per;
        logic [8:0]    p;
        logic [7:0]    h;
        logic [6:0]    q;
        logic [7:0]    dv;
        bit            found;
        res   = '0;
        found = 1'b0;
        if (rate != 23'd0)
        begin
            ratio = clk_hz / rate;
            base  = ratio - FIXED_OVERHEAD - 2 * longint'(filt);
            for (int d = 0; d < DIVIDER_LIMIT; d++)
            begin
                per = base / longint'(d + 1) - PERIOD_OFFSET;
                if (!found && per >= PERIOD_LOW && per < PERIOD_HIGH)
                begin
                    found          = 1'b1;
                    p              = per[8:0];
                    h              = p[8:1];
                    q              = p[8:2];
                    dv             = d[7:0];
                    res.ok         = 1'b1;
                    res.divider    = dv;
                    res.period     = p;
                    res.word_one   = {h, h, h, 8'd0};
                    res.word_two   = {1'b0, q, 8'd0, h, h};
                    res.word_three = {dv, 7'd0, p};
                    res.data_hold  = q;
                end
            end
        end
        return res;
    endfunction

    // Report one field that differs; gives the number of mismatches
    function automatic int field_diff(
        input string       label,
        input logic [31:0] want,
        input logic [31:0] got
    );
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, label, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Track the clock setting, queue predictions and check result beats
    always @(posedge clk or negedge rst_n)
    begin
        timing_words_t want;
        timing_words_t got;
        int            errs;
        if (!rst_n)
        begin
            clock_hz   <= CLOCK_RESET_HZ;
            beats_in   <= 0;
            beats_out  <= 0;
            fail_count <= 0;
            timing_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                beats_out <= beats_out + 1;
                got.ok         = m_tdata[0];
                got.divider    = m_tdata[8:1];
                got.period     = m_tdata[17:9];
                got.word_one   = m_tdata[49:18];
                got.word_two   = m_tdata[81:50];
                got.word_three = m_tdata[105:82];
                got.data_hold  = m_tdata[112:106];
                if (timing_q.size() == 0)
                begin
                    $display("%0t ns: result beat with nothing expected, expected none, actual 0x%0h",
                             $time, m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = timing_q.pop_front();
                    errs = field_diff("ok", 32'(want.ok), 32'(got.ok))
                         + field_diff("clock_divider", 32'(want.divider), 32'(got.divider))
                         + field_diff("period_cycles", 32'(want.period), 32'(got.period))
                         + field_diff("timing_word_one", want.word_one, got.word_one)
                         + field_diff("timing_word_two", want.word_two, got.word_two)
                         + field_diff("timing_word_three", 32'(want.word_three),
                                      32'(got.word_three))
                         + field_diff("data_hold_word", 32'(want.data_hold),
                                      32'(got.data_hold));
                    if (errs != 0)
                    begin
                        fail_count <= fail_count + errs;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                timing_q.push_back(search_timing(clock_hz, s_tdata[22:0], s_tdata[25:23]));
                beats_in <= beats_in + 1;
            end
            if (cfg_we)
            begin
                clock_hz <= cfg_wdata;
            end
        end
    end

endmodule

[sim/tb_i2c_timing_divider_search_top.sv]
// ----------------------------------------------------------------------------
// tb_i2c_timing_divider_search_top
// Stimulus and verdict for the I2C timing divider search block.
// ----------------------------------------------------------------------------
// Resets the block, then runs a directed set of rates, filters and input
// clocks around the edges of the divider search, followed by phases of random
// rates under a range of clock settings. The clock is only rewritten while no
// result is outstanding. Both stream sides idle in random bursts except near
// the end. Checking is done by the checker instance beside the block.
// ----------------------------------------------------------------------------

module tb_i2c_timing_divider_search_top;

    timeunit 1ns;
    timeprecision 1ps;

    import i2ctds_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_BEATS  = 200;
    localparam int CALM_BEATS   = 150;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [22:0] RATE_MAX = 23'h7FFFFF;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata   = '0;   // [22:0] bus_rate_hz, [25:23] filter_cycles
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [119:0] m_tdata;          // [0] ok, [8:1] clock_divider, [17:9] period_cycles,
                                    // [49:18] word one, [81:50] word two,
                                    // [105:82] word three, [112:106] data hold
    logic         cfg_we    = 1'b0;
    logic [29:0]  cfg_wdata = '0;

    int           fail_count;
    int           pending;
    int           cycles    = 0;
    int           ready_hold = 0;
    bit           calm      = 1'b0;
    logic [29:0]  clock_setting = CLOCK_RESET_HZ;

    i2c_timing_divider_search_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    i2ctds_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock: 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Drop m_tready in random bursts, none once calm
    always @(posedge clk)
    begin
        if (ready_hold != 0)
        begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            ready_hold <= $urandom_range(0, 6);
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Offer one beat, after an optional idle burst, and hold until accepted
    task automatic send_rate(input logic [22:0] rate, input logic [2:0] filt);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, filt, rate};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
    endtask

    // Write the input clock once every outstanding result has arrived
    task automatic write_clock(input logic [29:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        clock_setting = value;
    endtask

    // Directed beat under a given clock setting
    task automatic apply(input logic [29:0] clk_hz, input logic [22:0] rate,
                         input logic [2:0] filt);
        if (clk_hz != clock_setting)
        begin
            write_clock(clk_hz);
        end
        send_rate(rate, filt);
    endtask

    // Pick a rate: mostly aimed into the searchable span, the rest noise
    function automatic logic [22:0] pick_rate(input logic [29:0] clk_hz,
                                              input logic [2:0] filt);
        int unsigned mode;
        int unsigned ratio;
        int unsigned rate;
        mode = $urandom_range(0, 9);
        if (mode <= 5)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                ratio = $urandom_range(0, 600);
            end
            else
            begin
                ratio = $urandom_range(500, 135000);
            end
            rate = clk_hz / (ratio + FIXED_OVERHEAD + 2 * filt);
            if (rate == 0)
            begin
                rate = 1;
            end
            if (rate > RATE_MAX)
            begin
                rate = RATE_MAX;
            end
        end
        else if (mode == 6)
        begin
            rate = $urandom & RATE_MAX;
        end
        else if (mode == 7)
        begin
            rate = $urandom_range(1, 5000000);
        end
        else if (mode == 8)
        begin
            rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1000);
        end
        else
        begin
            rate = RATE_MAX - $urandom_range(0, 255);
        end
        return rate[22:0];
    endfunction

    // Clock setting for each random phase, extremes among them
    function automatic logic [29:0] pick_clock(input int phase);
        case (phase)
            0:       return 30'd1000000000;
            1:       return 30'($urandom_range(1, 1000000000));
            2:       return 30'd1;
            3:       return 30'($urandom_range(12, 140000));
            4:       return 30'($urandom);
            5:       return 30'($urandom_range(1000000, 200000000));
            6:       return 30'($urandom_range(1, 1000000000));
            default: return CLOCK_RESET_HZ;
        endcase
    endfunction

    // Main sequence
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset clock: typical rates, zero rate, negative base, huge base
        apply(CLOCK_RESET_HZ, 23'd100000, 3'd0);
        apply(CLOCK_RESET_HZ, 23'd400000, 3'd7);
        apply(CLOCK_RESET_HZ, 23'd0, 3'd3);
        apply(CLOCK_RESET_HZ, RATE_MAX, 3'd7);
        apply(CLOCK_RESET_HZ, 23'd1, 3'd0);
        apply(CLOCK_RESET_HZ, 23'd5000000, 3'd0);
        apply(CLOCK_RESET_HZ, 23'd0, 3'd0);

        // Base at the edges of the search: 3, 4, 4 at the widest filter, 513, 514, last fit, first miss
        apply(30'd11, 23'd1, 3'd0);
        apply(30'd12, 23'd1, 3'd0);
        apply(30'd26, 23'd1, 3'd7);
        apply(30'd521, 23'd1, 3'd0);
        apply(30'd522, 23'd1, 3'd0);
        apply(30'd131591, 23'd1, 3'd0);
        apply(30'd131592, 23'd1, 3'd0);

        // Zero and minimum input clock
        apply(30'd0, 23'd1, 3'd0);
        apply(30'd1, 23'd1, 3'd0);

        // Fastest clock in range and the widest register value
        apply(30'd1000000000, 23'd5000000, 3'd7);
        apply(30'd1000000000, 23'd1000000, 3'd2);
        apply(30'd1000000000, RATE_MAX, 3'd5);
        apply(30'd1000000000, 23'd7600, 3'd0);
        apply(30'h3FFFFFFF, 23'd4194304, 3'd5);
        apply(30'h3FFFFFFF, 23'd8192, 3'd1);

        // Random phases, each under its own clock setting
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            write_clock(pick_clock(ph));
            for (int k = 0; k < PHASE_BEATS; k++)
            begin
                logic [2:0] filt;
                filt = 3'($urandom_range(0, 7));
                if (ph == PHASE_COUNT - 1 && k >= PHASE_BEATS - CALM_BEATS)
                begin
                    calm = 1'b1;
                end
                send_rate(pick_rate(clock_setting, filt), filt);
            end
        end

        // Drain outstanding results, then let the block settle
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
